// ----- hdl/tweh_pkg.sv -----
// shared types, constants and controller codes for the takeoff weight and hover estimator
// no dependencies
package tweh_pkg;

  typedef struct packed {
    logic               mode;
    logic               armed;
    logic [31:0]        tick_ms;
    logic [15:0]        throttle;
    logic signed [15:0] accel_z;
    logic signed [15:0] climb_rate;
  } sample_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [14:0] weight_g;
    logic [15:0] hover_level;
    logic        window_open;
    logic        estimate_done;
  } result_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 3'd5;

  localparam logic [14:0] RST_DEFAULT_WEIGHT = 15'd1000;
  localparam logic [14:0] RST_MIN_WEIGHT     = 15'd200;
  localparam logic [14:0] RST_MAX_WEIGHT     = 15'd5000;
  localparam logic [15:0] RST_WINDOW_MS      = 16'd2000;
  localparam logic [15:0] RST_HOVER_HOLD     = 16'd3000;
  localparam logic [15:0] RST_MIN_SAMPLES    = 16'd10;

  localparam logic [1:0] PHASE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_ESTIMATE = 2'd1;
  localparam logic [1:0] PHASE_COLLECT  = 2'd2;

  localparam logic [15:0]        THR_OPEN      = 16'd19661;
  localparam logic [15:0]        THR_HOVER_MIN = 16'd13108;
  localparam logic [15:0]        THR_HOVER_MAX = 16'd58982;
  localparam logic signed [15:0] CLIMB_OPEN    = 16'sd128;
  localparam logic signed [15:0] HOVER_VEL     = 16'sd51;
  localparam logic signed [15:0] HOVER_VEL_NEG = -16'sd51;
  localparam logic [15:0]        HOVER_SMALL   = 16'd655;
  localparam logic [15:0]        HOVER_LO      = 16'd19661;
  localparam logic [15:0]        HOVER_HI      = 16'd52429;
  localparam logic [15:0]        HOVER_HALF    = 16'd32768;

  // divide by ten through reciprocal, exact for 20 bit operands
  localparam logic [19:0] RECIP10       = 20'd838861;
  localparam int          RECIP10_SHIFT = 23;

  localparam int DIV_NW = 60;
  localparam int DIV_DW = 45;
  localparam int DIV_QW = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_E1,
    S_D1,
    S_H,
    S_M2,
    S_M3,
    S_D2,
    S_W,
    S_HOV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic win_step;
    logic div1_start;
    logic hclamp;
    logic mul_step;
    logic div2_start;
    logic wclamp;
    logic hov_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic flight;
    logic need_div;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ----- hdl/tweh_divider.sv -----
// restoring divider, one quotient bit per cycle, quotient saturates on overflow
// depends on tweh_pkg
module tweh_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tweh_pkg::DIV_NW-1:0] num,
  input  logic [tweh_pkg::DIV_DW-1:0] den,
  output logic [tweh_pkg::DIV_QW-1:0] quot,
  output logic                        done
);
  import tweh_pkg::*;

  localparam int SW = DIV_DW + DIV_QW;
  localparam int CW = $clog2(DIV_QW + 1);
  localparam int IW = $clog2(DIV_QW);

  logic [SW-1:0]     rem;
  logic [SW-1:0]     dsh;
  logic [DIV_QW-1:0] q;
  logic              ovf;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              ge;

  assign ge   = rem >= dsh;
  assign quot = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if ((cnt == CW'(DIV_QW) && ge) || cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= SW'(num);
      dsh <= {den, {DIV_QW{1'b0}}};
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dsh <= dsh >> 1;
      if (cnt == CW'(DIV_QW)) begin
        if (ge) begin
          ovf <= 1'b1;
        end
      end else if (ge) begin
        rem             <= rem - dsh;
        q[cnt[IW-1:0]]  <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tweh_datapath.sv -----
// estimator state, window sums, evaluation arithmetic, hover filter and result register
// depends on tweh_pkg and tweh_divider
module tweh_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tweh_pkg::cmd_t                 cmd,
  output tweh_pkg::status_t              st,
  input  tweh_pkg::sample_t              sample,
  input  logic                           cfg_valid,
  input  logic [tweh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tweh_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tweh_pkg::result_t              result
);
  import tweh_pkg::*;

  logic [14:0] default_weight_g;
  logic [14:0] min_weight_g;
  logic [14:0] max_weight_g;
  logic [15:0] window_ms;
  logic [15:0] hover_hold_ms;
  logic [15:0] min_window_samples;

  logic [1:0]         learn_phase;
  logic               window_active;
  logic [31:0]        window_start;
  logic signed [31:0] accel_sum;
  logic [31:0]        throttle_sum;
  logic [15:0]        window_count;
  logic [14:0]        weight_est;
  logic [15:0]        hover_est;
  logic [31:0]        hover_since;
  logic               done_r;

  sample_t     smp;
  logic [27:0] hk;
  logic [58:0] prod;

  logic               flight;
  logic [31:0]        elapsed;
  logic               in_window;
  logic               enough;
  logic               climb_go;
  logic signed [40:0] a_ext;
  logic signed [40:0] a_x100;
  logic [40:0]        n_x;
  logic               heavy;
  logic               eval_now;
  logic               do_open;
  logic               do_acc;
  logic               do_default;
  logic signed [32:0] acc_s;
  logic signed [31:0] acc_next;
  logic [32:0]        ts;
  logic [31:0]        thr_next;

  logic [30:0]        au;
  logic [49:0]        t_x;
  logic [36:0]        a_x50;
  logic [37:0]        a_x100u;
  logic [43:0]        t_x3924;
  logic [44:0]        t_x7848;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               div_start;
  logic [DIV_QW-1:0]  div_q;
  logic               div_done;

  logic [15:0] h_cl;
  logic [14:0] w_cl;

  logic        steady;
  logic        held;
  logic [19:0] hx;
  logic [39:0] hxq;
  logic [15:0] refined;

  assign flight    = !smp.mode && smp.armed;
  assign elapsed   = smp.tick_ms - window_start;
  assign in_window = elapsed < {16'd0, window_ms};
  assign enough    = window_count >= min_window_samples;
  assign climb_go  = (smp.climb_rate > CLIMB_OPEN) && (smp.throttle >= THR_OPEN);

  // average accel above g plus one half, scaled by 100 and by count
  assign a_ext  = 41'(accel_sum);
  assign a_x100 = a_ext * 41'sd100;
  assign n_x    = 41'(window_count) * 41'd263936;
  assign heavy  = (a_x100 > $signed(n_x)) && (throttle_sum != 32'd0);

  assign eval_now   = flight && window_active && !in_window && enough;
  assign do_open    = smp.mode || (flight && !window_active && climb_go);
  assign do_acc     = flight && window_active && in_window;
  assign do_default = eval_now && !heavy;

  assign acc_s    = 33'(accel_sum) + 33'(smp.accel_z);
  assign acc_next = (acc_s[32] != acc_s[31]) ?
                    (acc_s[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : acc_s[31:0];
  assign ts       = 33'(throttle_sum) + 33'(smp.throttle);
  assign thr_next = ts[32] ? '1 : ts[31:0];

  assign au      = accel_sum[30:0];
  assign t_x     = 50'(throttle_sum) * 50'd251136;
  assign a_x50   = 37'(au) * 37'd50;
  assign a_x100u = 38'(au) * 38'd100;
  assign t_x3924 = 44'(throttle_sum) * 44'd3924;
  assign t_x7848 = 45'(throttle_sum) * 45'd7848;

  assign div_start = cmd.div1_start | cmd.div2_start;
  assign div_num   = cmd.div2_start ? (60'(prod) + 60'(t_x3924)) : (60'(t_x) + 60'(a_x50));
  assign div_den   = cmd.div2_start ? t_x7848 : 45'(a_x100u);

  tweh_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .done  (div_done)
  );

  always_comb begin
    if (div_q < HOVER_LO) begin
      h_cl = HOVER_LO;
    end else if (div_q > HOVER_HI) begin
      h_cl = HOVER_HI;
    end else begin
      h_cl = div_q;
    end
    if (div_q < {1'b0, min_weight_g}) begin
      w_cl = min_weight_g;
    end else if (div_q > {1'b0, max_weight_g}) begin
      w_cl = max_weight_g;
    end else begin
      w_cl = div_q[14:0];
    end
  end

  assign steady  = (smp.climb_rate >= HOVER_VEL_NEG) && (smp.climb_rate <= HOVER_VEL) &&
                   (smp.throttle >= THR_HOVER_MIN) && (smp.throttle <= THR_HOVER_MAX);
  assign held    = (smp.tick_ms - hover_since) >= {16'd0, hover_hold_ms};
  assign hx      = 20'(hover_est) * 20'd9 + 20'(smp.throttle) + 20'd5;
  assign hxq     = 40'(hx) * 40'(RECIP10);
  assign refined = hxq[RECIP10_SHIFT+15:RECIP10_SHIFT];

  assign st.flight   = flight;
  assign st.need_div = eval_now && heavy;
  assign st.div_done = div_done;
  assign st.out_busy = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_weight_g   <= RST_DEFAULT_WEIGHT;
      min_weight_g       <= RST_MIN_WEIGHT;
      max_weight_g       <= RST_MAX_WEIGHT;
      window_ms          <= RST_WINDOW_MS;
      hover_hold_ms      <= RST_HOVER_HOLD;
      min_window_samples <= RST_MIN_SAMPLES;
      learn_phase        <= PHASE_IDLE;
      window_active      <= 1'b0;
      window_start       <= '0;
      accel_sum          <= '0;
      throttle_sum       <= '0;
      window_count       <= '0;
      weight_est         <= RST_DEFAULT_WEIGHT;
      hover_est          <= HOVER_HALF;
      hover_since        <= '0;
      done_r             <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DEFAULT_WEIGHT: default_weight_g   <= cfg_data[14:0];
          CFG_MIN_WEIGHT:     min_weight_g       <= cfg_data[14:0];
          CFG_MAX_WEIGHT:     max_weight_g       <= cfg_data[14:0];
          CFG_WINDOW_MS:      window_ms          <= cfg_data;
          CFG_HOVER_HOLD:     hover_hold_ms      <= cfg_data;
          CFG_MIN_SAMPLES:    min_window_samples <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.latch) begin
        done_r <= 1'b0;
      end

      if (cmd.win_step) begin
        if (do_open) begin
          window_active <= 1'b1;
          window_start  <= smp.tick_ms;
          accel_sum     <= '0;
          throttle_sum  <= '0;
          window_count  <= '0;
          learn_phase   <= PHASE_ESTIMATE;
        end else if (do_acc) begin
          accel_sum    <= acc_next;
          throttle_sum <= thr_next;
          if (window_count != 16'hFFFF) begin
            window_count <= window_count + 16'd1;
          end
        end else if (do_default) begin
          weight_est    <= default_weight_g;
          hover_est     <= HOVER_HALF;
          window_active <= 1'b0;
          learn_phase   <= PHASE_COLLECT;
          done_r        <= 1'b1;
        end
      end

      if (cmd.hclamp) begin
        hover_est <= h_cl;
      end

      if (cmd.wclamp) begin
        weight_est    <= w_cl;
        window_active <= 1'b0;
        learn_phase   <= PHASE_COLLECT;
        done_r        <= 1'b1;
      end

      if (cmd.hov_step) begin
        if (steady) begin
          if (hover_since == 32'd0) begin
            hover_since <= smp.tick_ms;
          end else if (held) begin
            hover_est <= (hover_est <= HOVER_SMALL) ? smp.throttle : refined;
          end
        end else begin
          hover_since <= '0;
        end
      end

      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      smp <= sample;
    end
    if (cmd.hclamp) begin
      hk <= 28'(h_cl) * 28'd3125;
    end
    if (cmd.mul_step) begin
      prod <= 59'(au) * 59'(hk);
    end
    if (cmd.load_out) begin
      result.phase         <= learn_phase;
      result.weight_g      <= weight_est;
      result.hover_level   <= hover_est;
      result.window_open   <= window_active;
      result.estimate_done <= done_r;
    end
  end

endmodule

// ----- hdl/tweh_ctrl.sv -----
// controller state machine sequencing one request through the datapath
// depends on tweh_pkg
module tweh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  tweh_pkg::status_t st,
  output tweh_pkg::cmd_t    cmd
);
  import tweh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    sample_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        sample_ready = !rst;
        if (sample_valid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        cmd.win_step = 1'b1;
        if (st.need_div) begin
          state_next = S_E1;
        end else if (st.flight) begin
          state_next = S_HOV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_E1: begin
        cmd.div1_start = 1'b1;
        state_next     = S_D1;
      end
      S_D1: begin
        if (st.div_done) begin
          state_next = S_H;
        end
      end
      S_H: begin
        cmd.hclamp = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_step = 1'b1;
        state_next   = S_M3;
      end
      S_M3: begin
        cmd.div2_start = 1'b1;
        state_next     = S_D2;
      end
      S_D2: begin
        if (st.div_done) begin
          state_next = S_W;
        end
      end
      S_W: begin
        cmd.wclamp = 1'b1;
        state_next = S_HOV;
      end
      S_HOV: begin
        cmd.hov_step = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/takeoff_weight_hover_estimator.sv -----
// a flight sample passes the window and hover steps; a command or unarmed sample only the window step
// a close with net climb runs two quotients in turn through one serial divider
// one request at a time; the next is taken once the result is registered
// the result register holds a finished result while the next request is taken
// reset: synchronous active high rst, state and config registers to their default values, phase idle
// top level, depends on tweh_pkg, tweh_ctrl and tweh_datapath
module takeoff_weight_hover_estimator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  tweh_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tweh_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tweh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tweh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tweh_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = !rst;

  tweh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .st           (st),
    .cmd          (cmd)
  );

  tweh_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- hdl/tweh_check.sv -----
// port level checks for the estimator and the bind that attaches them
// depends on tweh_pkg and takeoff_weight_hover_estimator
module tweh_check (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input tweh_pkg::result_t result
);
  import tweh_pkg::*;

  a_open_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.window_open |-> result.phase == PHASE_ESTIMATE)
    else $error("open window without estimating phase");

  a_done_closed: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.estimate_done |-> !result.window_open &&
                                             result.phase == PHASE_COLLECT)
    else $error("closed estimate with window still open");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("request taken while previous one in flight");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind takeoff_weight_hover_estimator tweh_check u_check (.*);
